FILE: hw/rtl/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg
// Shared widths, codes and controller/datapath interface types for the
// double-hashing hash table.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int KEY_W    = 31;
  localparam int STATUS_W = 3;
  localparam int COMPS_W  = 6;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // slot marks
  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    hash_step;
    logic    stride_load;
    logic    stride_step;
    logic    adv;
    logic    rec_del;
    logic    wr_ins;
    logic    wr_del;
    logic    finish;
    logic    full;
    status_t code;
  } dht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       clr_last;
    logic       hash_last;
    logic       stride_last;
    logic       op_del;
    logic [1:0] mark;
    logic       key_eq;
    logic       probe_last;
    logic       have_del;
  } dht_stat_t;

endpackage

FILE: hw/rtl/dht_datapath.sv
// ----------------------------------------------------------------------------
// dht_datapath
// Slot memories, serial modulo reduction of the key, probe position
// stepping, comparison counting and the result register.
// ----------------------------------------------------------------------------
module dht_datapath #(
  parameter int TABLE_SIZE = 37,
  parameter int STEP_PRIME = 13
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dht_pkg::dht_cmd_t            cmd,
  output dht_pkg::dht_stat_t           stat,
  input  logic                         in_op,
  input  logic [dht_pkg::KEY_W-1:0]    in_key,
  output logic [dht_pkg::STATUS_W-1:0] res_status,
  output logic [dht_pkg::COMPS_W-1:0]  res_comps
);
  import dht_pkg::*;

  localparam int TW  = $clog2(TABLE_SIZE);
  localparam int PW  = $clog2(STEP_PRIME);
  localparam int SW  = $clog2(STEP_PRIME + 1);
  localparam int SIW = $clog2(SW);
  localparam int BW  = $clog2(KEY_W);
  localparam int CW  = $clog2(TABLE_SIZE + 1);

  logic [1:0]       marks [TABLE_SIZE];
  logic [KEY_W-1:0] keys  [TABLE_SIZE];

  logic [TW-1:0]    clr_cnt_r;
  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic [BW-1:0]    bit_r;
  logic [TW-1:0]    pos_r;
  logic [PW-1:0]    srem_r;
  logic [SW-1:0]    sval_r;
  logic [SIW-1:0]   sbit_r;
  logic [TW-1:0]    stride_r;
  logic [TW-1:0]    cnt_r;
  logic [CW-1:0]    comps_r;
  logic             have_del_r;
  logic [TW-1:0]    tomb_slot_r;
  logic [1:0]       mark_rd_r;
  logic [KEY_W-1:0] key_rd_r;
  logic [STATUS_W-1:0] status_r;
  logic [COMPS_W-1:0]  comps_out_r;

  logic [TW:0]      hsum, tsum, psum;
  logic [PW:0]      ssum;
  logic [TW-1:0]    hred, tred, pred;
  logic [PW-1:0]    sred;
  logic [CW-1:0]    comps_inc;
  logic [TW-1:0]    ins_addr;
  logic             mark_we;
  logic [TW-1:0]    mark_wa;
  logic [1:0]       mark_wd;

  // one shift-and-subtract step of each remainder, and the modular probe advance
  always_comb begin
    hsum = {pos_r, key_r[bit_r]};
    hred = (hsum >= (TW+1)'(TABLE_SIZE)) ? TW'(hsum - (TW+1)'(TABLE_SIZE)) : TW'(hsum);
    ssum = {srem_r, key_r[bit_r]};
    sred = (ssum >= (PW+1)'(STEP_PRIME)) ? PW'(ssum - (PW+1)'(STEP_PRIME)) : PW'(ssum);
    tsum = {stride_r, sval_r[sbit_r]};
    tred = (tsum >= (TW+1)'(TABLE_SIZE)) ? TW'(tsum - (TW+1)'(TABLE_SIZE)) : TW'(tsum);
    psum = {1'b0, pos_r} + {1'b0, stride_r};
    pred = (psum >= (TW+1)'(TABLE_SIZE)) ? TW'(psum - (TW+1)'(TABLE_SIZE)) : TW'(psum);
  end

  assign comps_inc = comps_r + ((mark_rd_r == MARK_USED) ? CW'(1) : CW'(0));
  // the first deleted slot wins; otherwise the slot under the probe
  assign ins_addr  = have_del_r ? tomb_slot_r : pos_r;

  always_comb begin
    mark_we = cmd.clr_step | cmd.wr_ins | cmd.wr_del;
    if (cmd.clr_step) begin
      mark_wa = clr_cnt_r;
      mark_wd = MARK_EMPTY;
    end else if (cmd.wr_ins) begin
      mark_wa = ins_addr;
      mark_wd = MARK_USED;
    end else begin
      mark_wa = pos_r;
      mark_wd = MARK_DELETED;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks[mark_wa] <= mark_wd;
    end
    if (cmd.wr_ins) begin
      keys[ins_addr] <= key_r;
    end
    mark_rd_r <= marks[pos_r];
    key_rd_r  <= keys[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      key_r  <= in_key;
      bit_r  <= BW'(KEY_W - 1);
      pos_r  <= '0;
      srem_r <= '0;
    end else if (cmd.hash_step) begin
      bit_r  <= bit_r - BW'(1);
      pos_r  <= hred;
      srem_r <= sred;
    end else if (cmd.adv) begin
      pos_r <= pred;
    end

    if (cmd.stride_load) begin
      sval_r     <= SW'(srem_r) + SW'(1);
      sbit_r     <= SIW'(SW - 1);
      stride_r   <= '0;
      cnt_r      <= '0;
      comps_r    <= '0;
      have_del_r <= 1'b0;
    end else if (cmd.stride_step) begin
      sbit_r   <= sbit_r - SIW'(1);
      stride_r <= tred;
    end else if (cmd.adv) begin
      cnt_r   <= cnt_r + TW'(1);
      comps_r <= comps_inc;
    end

    if (cmd.rec_del && !have_del_r) begin
      have_del_r  <= 1'b1;
      tomb_slot_r <= pos_r;
    end

    if (cmd.finish) begin
      status_r    <= cmd.code;
      comps_out_r <= cmd.full ? COMPS_W'(TABLE_SIZE) : COMPS_W'(comps_inc);
    end
  end

  always_comb begin
    stat.clr_last    = (clr_cnt_r == TW'(TABLE_SIZE - 1));
    stat.hash_last   = (bit_r == '0);
    stat.stride_last = (sbit_r == '0);
    stat.op_del      = (op_r == OP_DELETE);
    stat.mark        = mark_rd_r;
    stat.key_eq      = (key_rd_r == key_r);
    stat.probe_last  = (cnt_r == TW'(TABLE_SIZE - 1));
    stat.have_del    = have_del_r;
  end

  assign res_status = status_r;
  assign res_comps  = comps_out_r;

endmodule

FILE: hw/rtl/dht_ctrl.sv
// ----------------------------------------------------------------------------
// dht_ctrl
// Sequencer: clears the slot marks after reset, then runs each operation
// through key reduction, stride reduction and the probe loop.
// ----------------------------------------------------------------------------
module dht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  dht_pkg::dht_stat_t stat,
  output dht_pkg::dht_cmd_t  cmd
);
  import dht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_SLOAD,
    S_STRIDE,
    S_READ,
    S_EVAL
  } state_t;

  state_t   state_r, state_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     out_busy;
  dht_cmd_t dec;
  logic     fin;

  assign out_busy = out_valid_r && !out_tready;

  // decide the outcome of one probe
  always_comb begin
    dec      = '0;
    dec.code = ST_INSERTED;
    fin      = 1'b0;
    if (!stat.op_del) begin
      if (stat.mark == MARK_EMPTY) begin
        fin        = 1'b1;
        dec.wr_ins = 1'b1;
        dec.code   = ST_INSERTED;
      end else if (stat.mark == MARK_USED) begin
        if (stat.key_eq) begin
          fin      = 1'b1;
          dec.code = ST_DUPLICATE;
        end else if (stat.probe_last) begin
          fin = 1'b1;
          if (stat.have_del) begin
            dec.wr_ins = 1'b1;
            dec.code   = ST_INSERTED;
          end else begin
            dec.full = 1'b1;
            dec.code = ST_FULL;
          end
        end else begin
          dec.adv = 1'b1;
        end
      end else begin
        if (stat.probe_last) begin
          fin        = 1'b1;
          dec.wr_ins = 1'b1;
          dec.code   = ST_INSERTED;
        end else begin
          dec.rec_del = 1'b1;
          dec.adv     = 1'b1;
        end
      end
    end else begin
      if (stat.mark == MARK_EMPTY) begin
        fin      = 1'b1;
        dec.code = ST_NOT_FOUND;
      end else if (stat.mark == MARK_USED && stat.key_eq) begin
        fin        = 1'b1;
        dec.wr_del = 1'b1;
        dec.code   = ST_DELETED;
      end else if (stat.probe_last) begin
        fin      = 1'b1;
        dec.code = ST_NOT_FOUND;
      end else begin
        dec.adv = 1'b1;
      end
    end
    dec.finish = fin;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.code      = ST_INSERTED;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (stat.hash_last) begin
          state_nxt = S_SLOAD;
        end
      end
      S_SLOAD: begin
        cmd.stride_load = 1'b1;
        state_nxt       = S_STRIDE;
      end
      S_STRIDE: begin
        cmd.stride_step = 1'b1;
        if (stat.stride_last) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // hold a finishing probe while the previous result is still waiting
        if (!(fin && out_busy)) begin
          cmd = dec;
          if (fin) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

FILE: hw/rtl/double_hash_table_insert_delete.sv
// ----------------------------------------------------------------------------
// double_hash_table_insert_delete
// Open-addressed hash table with double hashing and deleted-slot markers.
// ----------------------------------------------------------------------------
// Each input transfer inserts (tuser 0) or deletes (tuser 1) a 31-bit key and
// returns one result transfer with a status code and the number of stored
// keys compared. After reset the block sweeps the slot marks to empty, one
// slot a cycle, and takes no input during the sweep.
// One operation is processed at a time; a finished result waits in the
// output register while the next input is taken. The key is reduced modulo
// TABLE_SIZE and STEP_PRIME one bit a cycle, then the stride modulo
// TABLE_SIZE one bit a cycle, and each probe does a registered read of the
// slot memories followed by the decision; a finishing decision waits while
// the previous result is still waiting in the output register.
// ----------------------------------------------------------------------------
module double_hash_table_insert_delete #(
  parameter int TABLE_SIZE = 37,
  parameter int STEP_PRIME = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] key, [31] zero
  input  logic [0:0]  in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [2:0] status, [8:3] comparisons, [15:9] zero
);
  import dht_pkg::*;

  dht_cmd_t            cmd;
  dht_stat_t           stat;
  logic [STATUS_W-1:0] res_status;
  logic [COMPS_W-1:0]  res_comps;

  dht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  dht_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .STEP_PRIME (STEP_PRIME)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_tuser[0]),
    .in_key     (in_tdata[KEY_W-1:0]),
    .res_status (res_status),
    .res_comps  (res_comps)
  );

  assign out_tdata = {7'd0, res_comps, res_status};

endmodule
